FILE: sv/bsl_pkg.sv
// bsl_pkg: shared types, character codes, token type codes and keyword tables
// for the basic source lexer. No dependencies.
package bsl_pkg;

  localparam int unsigned LENGTH_BITS_DEF  = 16;
  localparam int unsigned PREFIX_BYTES_DEF = 7;
  localparam int unsigned TOK_LEN_W        = 16;
  localparam int unsigned KW_BYTES         = 7;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef enum logic [3:0] {
    TT_UNDEF    = 4'd0,
    TT_DIM      = 4'd1,
    TT_TYPE     = 4'd2,
    TT_KEYWORD  = 4'd3,
    TT_FUNCTION = 4'd4,
    TT_REM      = 4'd5,
    TT_STRING   = 4'd6,
    TT_IDENT    = 4'd7,
    TT_NUMBER   = 4'd8,
    TT_ARITH    = 4'd9,
    TT_RELOP    = 4'd10,
    TT_EQUALS   = 4'd11,
    TT_COLON    = 4'd12,
    TT_SEMI     = 4'd13,
    TT_COMMA    = 4'd14,
    TT_NEWLINE  = 4'd15
  } tok_type_t;

  typedef logic [KW_BYTES-1:0][7:0] kw_t;

  typedef struct packed {
    logic                 all_digits;
    logic                 ident_ok;
    logic [7:0]           prev_byte;
  } word_flags_t;

  typedef struct packed {
    logic [3:0]           ttype;
    logic [TOK_LEN_W-1:0] tlen;
    logic                 last;
  } tok_t;

  // keyword tables, byte 0 is the first character
  localparam kw_t KW_DIM     = {8'h00, 8'h00, 8'h00, 8'h00, "M", "I", "D"};
  localparam kw_t KW_AS      = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "S", "A"};
  localparam kw_t KW_LET     = {8'h00, 8'h00, 8'h00, 8'h00, "T", "E", "L"};
  localparam kw_t KW_REM     = {8'h00, 8'h00, 8'h00, 8'h00, "M", "E", "R"};
  localparam kw_t KW_PRINT   = {8'h00, 8'h00, "T", "N", "I", "R", "P"};
  localparam kw_t KW_GOTO    = {8'h00, 8'h00, 8'h00, "O", "T", "O", "G"};
  localparam kw_t KW_END     = {8'h00, 8'h00, 8'h00, 8'h00, "D", "N", "E"};
  localparam kw_t KW_RND     = {8'h00, 8'h00, 8'h00, 8'h00, "D", "N", "R"};
  localparam kw_t KW_INPUT   = {8'h00, 8'h00, "T", "U", "P", "N", "I"};
  localparam kw_t KW_INTEGER = {"R", "E", "G", "E", "T", "N", "I"};
  localparam kw_t KW_STRING  = {8'h00, "G", "N", "I", "R", "T", "S"};
  localparam kw_t KW_LONG    = {8'h00, 8'h00, 8'h00, "G", "N", "O", "L"};
  localparam kw_t KW_SINGLE  = {8'h00, "E", "L", "G", "N", "I", "S"};
  localparam kw_t KW_DOUBLE  = {8'h00, "E", "L", "B", "U", "O", "D"};

  // whole-word compare against a keyword of kw_n bytes
  function automatic logic word_eq(input kw_t pfx, input logic [3:0] n,
                                   input kw_t kw, input logic [3:0] kw_n);
    logic eq;
    int   i;
    eq = (n == kw_n);
    for (i = 0; i < KW_BYTES; i++) begin
      if ((4'(i) < kw_n) && (pfx[i] != kw[i])) begin
        eq = 1'b0;
      end
    end
    return eq;
  endfunction

  function automatic logic word_is1(input kw_t pfx, input logic [3:0] n,
                                    input logic [7:0] a);
    return (n == 4'd1) && (pfx[0] == a);
  endfunction

  function automatic logic word_is2(input kw_t pfx, input logic [3:0] n,
                                    input logic [7:0] a, input logic [7:0] b);
    return (n == 4'd2) && (pfx[0] == a) && (pfx[1] == b);
  endfunction

endpackage

FILE: sv/bsl_classify.sv
// bsl_classify: priority classification of one finished word into a token type.
// Depends on bsl_pkg.
module bsl_classify #(
  parameter int unsigned LENGTH_BITS = bsl_pkg::LENGTH_BITS_DEF
) (
  input  logic [LENGTH_BITS-1:0] word_len,
  input  bsl_pkg::kw_t           word_pfx,
  input  bsl_pkg::word_flags_t   flags,
  output bsl_pkg::tok_type_t     word_type
);
  import bsl_pkg::*;

  logic [3:0] short_len;
  logic       nonempty;

  always_comb begin
    short_len = (word_len <= LENGTH_BITS'(KW_BYTES)) ? word_len[3:0] : 4'd0;
    nonempty  = (word_len != '0);

    if (word_eq(word_pfx, short_len, KW_DIM, 4'd3)) begin
      word_type = TT_DIM;
    end else if (word_is1(word_pfx, short_len, "=")) begin
      word_type = TT_EQUALS;
    end else if (word_is1(word_pfx, short_len, ",")) begin
      word_type = TT_COMMA;
    end else if (word_is1(word_pfx, short_len, ":")) begin
      word_type = TT_COLON;
    end else if (word_is1(word_pfx, short_len, ";")) begin
      word_type = TT_SEMI;
    end else if (word_is1(word_pfx, short_len, CH_NL)) begin
      word_type = TT_NEWLINE;
    end else if (word_eq(word_pfx, short_len, KW_AS, 4'd2) ||
                 word_eq(word_pfx, short_len, KW_LET, 4'd3)) begin
      word_type = TT_KEYWORD;
    end else if (word_eq(word_pfx, short_len, KW_REM, 4'd3)) begin
      word_type = TT_REM;
    end else if (word_is1(word_pfx, short_len, "*") || word_is1(word_pfx, short_len, "/") ||
                 word_is1(word_pfx, short_len, "-") || word_is1(word_pfx, short_len, "+")) begin
      word_type = TT_ARITH;
    end else if (word_is1(word_pfx, short_len, ">") ||
                 word_is2(word_pfx, short_len, ">", "=") ||
                 word_is1(word_pfx, short_len, "<") ||
                 word_is2(word_pfx, short_len, "<", "=") ||
                 word_is2(word_pfx, short_len, "<", ">")) begin
      word_type = TT_RELOP;
    end else if (word_eq(word_pfx, short_len, KW_PRINT, 4'd5) ||
                 word_eq(word_pfx, short_len, KW_GOTO, 4'd4) ||
                 word_eq(word_pfx, short_len, KW_END, 4'd3) ||
                 word_eq(word_pfx, short_len, KW_RND, 4'd3) ||
                 word_eq(word_pfx, short_len, KW_INPUT, 4'd5)) begin
      word_type = TT_FUNCTION;
    end else if ((word_len > LENGTH_BITS'(1)) && (word_pfx[0] == CH_QUOTE) &&
                 (flags.prev_byte == CH_QUOTE)) begin
      word_type = TT_STRING;
    end else if (word_eq(word_pfx, short_len, KW_INTEGER, 4'd7) ||
                 word_eq(word_pfx, short_len, KW_STRING, 4'd6) ||
                 word_eq(word_pfx, short_len, KW_LONG, 4'd4) ||
                 word_eq(word_pfx, short_len, KW_SINGLE, 4'd6) ||
                 word_eq(word_pfx, short_len, KW_DOUBLE, 4'd6)) begin
      word_type = TT_TYPE;
    end else if (nonempty && flags.all_digits) begin
      word_type = TT_NUMBER;
    end else if (nonempty && flags.ident_ok) begin
      word_type = TT_IDENT;
    end else begin
      word_type = TT_UNDEF;
    end
  end

endmodule

FILE: sv/bsl_core.sv
// bsl_core: word state registers and the per-byte split and flush logic.
// Depends on bsl_pkg and bsl_classify.
module bsl_core #(
  parameter int unsigned LENGTH_BITS  = bsl_pkg::LENGTH_BITS_DEF,
  parameter int unsigned PREFIX_BYTES = bsl_pkg::PREFIX_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic [7:0]    src_byte,
  input  logic          src_eos,
  output bsl_pkg::tok_t tok0,
  output bsl_pkg::tok_t tok1,
  output logic [1:0]    tok_cnt
);
  import bsl_pkg::*;

  localparam int unsigned LB    = LENGTH_BITS;
  localparam int unsigned EXT_W = (LB > TOK_LEN_W) ? LB : TOK_LEN_W;
  localparam logic [LB-1:0] LEN_MAX = '1;

  logic                          str_r, str_nxt;
  logic [LB-1:0]                 len_r, len_nxt;
  logic [PREFIX_BYTES-1:0][7:0]  pfx_r, pfx_nxt;
  logic [7:0]                    prev_r, prev_nxt;
  logic                          dig_r, dig_nxt;
  logic                          idf_r, idf_nxt;

  logic                          c_dig, c_alpha, c_alnum;
  logic                          case_nl, case_word, case_sp, case_app;
  logic                          brk, flush_b, close, t_keep;
  logic                          s0_e, nl_e, t_e;
  logic [LB-1:0]                 base_len, t_len;
  logic                          base_dig, base_idf, t_dig, t_idf;
  logic [PREFIX_BYTES-1:0][7:0]  t_pfx;
  word_flags_t                   s0_flags, t_flags;
  tok_type_t                     s0_type, t_type;
  tok_t                          tok_s0, tok_nl, tok_app;

  function automatic logic [TOK_LEN_W-1:0] sat_len(input logic [LB-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    if ((ext >> TOK_LEN_W) != '0) begin
      return '1;
    end
    return ext[TOK_LEN_W-1:0];
  endfunction

  bsl_classify #(.LENGTH_BITS(LB)) u_cls_s0 (
    .word_len  (len_r),
    .word_pfx  (pfx_r[KW_BYTES-1:0]),
    .flags     (s0_flags),
    .word_type (s0_type)
  );

  bsl_classify #(.LENGTH_BITS(LB)) u_cls_t (
    .word_len  (t_len),
    .word_pfx  (t_pfx[KW_BYTES-1:0]),
    .flags     (t_flags),
    .word_type (t_type)
  );

  always_comb begin
    c_dig   = (src_byte >= "0") && (src_byte <= "9");
    c_alpha = ((src_byte >= "a") && (src_byte <= "z")) ||
              ((src_byte >= "A") && (src_byte <= "Z"));
    c_alnum = c_dig || c_alpha;

    case_nl   = !str_r && (src_byte == CH_NL);
    case_sp   = !str_r && (src_byte == CH_SPACE);
    case_word = !str_r && !case_nl && !case_sp && (len_r != '0);
    case_app  = !case_nl && !case_sp && !case_word;

    s0_flags = '{all_digits: dig_r, ident_ok: idf_r, prev_byte: prev_r};

    brk = (dig_r && !c_dig) || (idf_r && !c_alnum) ||
          (s0_type == TT_ARITH) || (s0_type == TT_RELOP) || (s0_type == TT_EQUALS);
    flush_b = case_word && brk;

    // word that the byte is appended to
    base_len = flush_b ? '0 : len_r;
    base_dig = flush_b || dig_r;
    base_idf = flush_b || idf_r;

    t_len = base_len + LB'(base_len != LEN_MAX);
    t_dig = base_dig && c_dig;
    t_idf = (base_len == '0) ? c_alpha : (base_idf && c_alnum);
    for (int i = 0; i < PREFIX_BYTES; i++) begin
      t_pfx[i] = (base_len == LB'(i)) ? src_byte : pfx_r[i];
    end
    t_flags = '{all_digits: t_dig, ident_ok: t_idf, prev_byte: src_byte};

    close  = case_app && str_r && (src_byte == CH_QUOTE);
    t_keep = (case_word || case_app) && !close;

    s0_e = flush_b || ((case_nl || case_sp) && (len_r != '0));
    nl_e = case_nl;
    t_e  = close || (src_eos && t_keep);

    tok_s0  = '{ttype: s0_type, tlen: sat_len(len_r), last: 1'b0};
    tok_nl  = '{ttype: TT_NEWLINE, tlen: TOK_LEN_W'(1), last: 1'b0};
    tok_app = '{ttype: t_type, tlen: sat_len(t_len), last: 1'b0};

    tok_cnt = 2'(s0_e) + 2'(nl_e) + 2'(t_e);
    tok0 = s0_e ? tok_s0 : (nl_e ? tok_nl : tok_app);
    tok1 = (s0_e && nl_e) ? tok_nl : tok_app;
    tok0.last = (tok_cnt == 2'd1);
    tok1.last = 1'b1;
  end

  always_comb begin
    str_nxt  = str_r;
    len_nxt  = len_r;
    prev_nxt = prev_r;
    dig_nxt  = dig_r;
    idf_nxt  = idf_r;
    pfx_nxt  = pfx_r;
    if (case_word || case_app) begin
      len_nxt  = t_len;
      prev_nxt = src_byte;
      dig_nxt  = t_dig;
      idf_nxt  = t_idf;
      pfx_nxt  = t_pfx;
    end
    if (case_app && (src_byte == CH_QUOTE)) begin
      str_nxt = !str_r;
    end
    if (case_nl || case_sp || close) begin
      len_nxt = '0;
      dig_nxt = 1'b1;
      idf_nxt = 1'b1;
    end
    if (src_eos) begin
      str_nxt  = 1'b0;
      len_nxt  = '0;
      prev_nxt = '0;
      dig_nxt  = 1'b1;
      idf_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      str_r  <= 1'b0;
      len_r  <= '0;
      prev_r <= '0;
      dig_r  <= 1'b1;
      idf_r  <= 1'b1;
    end else if (step_en) begin
      str_r  <= str_nxt;
      len_r  <= len_nxt;
      prev_r <= prev_nxt;
      dig_r  <= dig_nxt;
      idf_r  <= idf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      pfx_r <= pfx_nxt;
    end
  end

  a_str_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    str_r |-> (len_r != '0))
    else $error("string mode with an empty word");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (dig_r && idf_r) |-> (len_r == '0))
    else $error("word is both a digit run and an identifier");

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && src_eos) |=> ((len_r == '0) && !str_r))
    else $error("word state not cleared after end of source");

endmodule

FILE: sv/bsl_outbuf.sv
// bsl_outbuf: two-entry result register that hands out the tokens of one byte
// one transfer at a time. Depends on bsl_pkg.
module bsl_outbuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  logic [1:0]    load_cnt,
  input  bsl_pkg::tok_t load_tok0,
  input  bsl_pkg::tok_t load_tok1,
  output logic          can_load,
  input  logic          out_ready,
  output logic          out_valid,
  output bsl_pkg::tok_t out_tok
);
  import bsl_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  tok_t       slot0_r, slot0_nxt;
  tok_t       slot1_r, slot1_nxt;
  logic       fire;

  always_comb begin
    out_valid = (cnt_r != 2'd0);
    out_tok   = slot0_r;
    fire      = out_valid && out_ready;
    can_load  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (load) begin
      cnt_nxt   = load_cnt;
      slot0_nxt = load_tok0;
      slot1_nxt = load_tok1;
    end else if (fire) begin
      cnt_nxt   = cnt_r - 2'd1;
      slot0_nxt = slot1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result count out of range");

  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load)
    else $error("results loaded over a pending token");

  a_last_marks: assert property (@(posedge clk) disable iff (!rst_n)
    ((cnt_r == 2'd2) |-> (!slot0_r.last && slot1_r.last)) and
    ((cnt_r == 2'd1) |-> slot0_r.last))
    else $error("last-of-step flag misplaced");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tok.tlen != '0))
    else $error("zero-length token offered");

endmodule

FILE: sv/basic_source_lexer.sv
// basic_source_lexer: byte-stream BASIC tokenizer, top level.
// Depends on bsl_pkg, bsl_core, bsl_classify and bsl_outbuf.
// tokens: a byte's tokens pass the input register, then the result register, before
//   they are offered and can transfer out; a byte that causes no token just updates
//   the word state
// throughput: one byte per cycle while each byte causes at most one token and
//   out_ready stays high; a byte causing two tokens holds the next byte back while both drain
// reset: synchronous active-low rst_n empties both registers and the word state
module basic_source_lexer #(
  parameter int unsigned LENGTH_BITS  = bsl_pkg::LENGTH_BITS_DEF,
  parameter int unsigned PREFIX_BYTES = bsl_pkg::PREFIX_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_source_byte,
  input  logic                           in_end_of_source,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [3:0]                     out_token_type,
  output logic [bsl_pkg::TOK_LEN_W-1:0]  out_token_length,
  output logic                           out_last_of_step
);
  import bsl_pkg::*;

  // input register
  logic       in_v_r, in_v_nxt;
  logic [7:0] byte_r;
  logic       eos_r;

  // step handshake between input register and result register
  logic       step_en;
  logic       can_load;
  logic       in_xfer;

  // tokens of the current byte
  tok_t       tok0, tok1, out_tok;
  logic [1:0] tok_cnt;

  always_comb begin
    // the byte moves on once the result register has room for all its tokens
    step_en  = in_v_r && can_load;
    // input register refills in the same cycle it empties
    in_ready = !in_v_r || step_en;
    in_xfer  = in_valid && in_ready;
    if (in_xfer) begin
      in_v_nxt = 1'b1;
    end else if (step_en) begin
      in_v_nxt = 1'b0;
    end else begin
      in_v_nxt = in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  // payload holds until the next transfer, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_r <= in_source_byte;
      eos_r  <= in_end_of_source;
    end
  end

  // word splitting, classification and state update
  bsl_core #(
    .LENGTH_BITS  (LENGTH_BITS),
    .PREFIX_BYTES (PREFIX_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .src_byte (byte_r),
    .src_eos  (eos_r),
    .tok0     (tok0),
    .tok1     (tok1),
    .tok_cnt  (tok_cnt)
  );

  // result register, up to two tokens per byte
  bsl_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en),
    .load_cnt  (tok_cnt),
    .load_tok0 (tok0),
    .load_tok1 (tok1),
    .can_load  (can_load),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_tok   (out_tok)
  );

  assign out_token_type   = out_tok.ttype;
  assign out_token_length = out_tok.tlen;
  assign out_last_of_step = out_tok.last;

endmodule

FILE: tb/tb_basic_source_lexer.sv
// tb_basic_source_lexer: self-checking testbench for the basic source lexer,
// a directed table of source text followed by random BASIC phrases and noise.
// Depends on bsl_pkg and basic_source_lexer.
`timescale 1ns / 100ps

module tb_basic_source_lexer;
  import bsl_pkg::*;

  // bytes kept per word for keyword compares, and the length ceiling
  localparam int unsigned PFX          = PREFIX_BYTES_DEF;
  localparam int unsigned LEN_MAX      = (1 << LENGTH_BITS_DEF) - 1;
  localparam int unsigned TOK_MAX      = (1 << TOK_LEN_W) - 1;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned PAUSE_EVERY  = 250;
  localparam int unsigned DRAIN_CYCLES = 20;
  // the transfers of this run stay far below this ceiling
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct {
    tok_type_t            ttype;
    logic [TOK_LEN_W-1:0] tlen;
    logic                 last;
  } token_rec_t;

  // one row of directed source text; an empty text sends raw, reps times
  typedef struct {
    string       text;
    logic [7:0]  raw;
    int unsigned reps;
    bit          eos;
    bit          typed;
    tok_type_t   ttype;
    int unsigned tlen;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_source_byte;
  logic                 in_end_of_source;
  logic                 out_valid;
  logic                 out_ready;
  logic [3:0]           out_token_type;
  logic [TOK_LEN_W-1:0] out_token_length;
  logic                 out_last_of_step;

  // tokens still owed by the block, oldest first
  token_rec_t  pending_tokens[$];
  int unsigned mismatches;
  bit          no_idle;

  // lexer model state
  bit          lx_in_str;
  int unsigned lx_len;
  logic [7:0]  lx_pfx [PFX];
  logic [7:0]  lx_prev;
  bit          lx_digits;
  bit          lx_ident;

  // tokens caused by the byte being modeled
  token_rec_t  step_tok [2];
  int unsigned step_n;

  stim_row_t   stim_rows[$];
  logic [7:0]  phrase_bytes[$];

  string kw_words [14] = '{"DIM", "AS", "LET", "REM", "PRINT", "GOTO", "END", "RND",
                           "INPUT", "INTEGER", "STRING", "LONG", "SINGLE", "DOUBLE"};
  string op_chars = "+-*/<>=:;,";

  basic_source_lexer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_source_byte   (in_source_byte),
    .in_end_of_source (in_end_of_source),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_type   (out_token_type),
    .out_token_length (out_token_length),
    .out_last_of_step (out_last_of_step)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // lexer model
  // ---------------------------------------------------------------------------

  function automatic bit is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  // whole-word compare; only prefix bytes of the open word are ever looked at
  function automatic bit word_match(input string s);
    if ((lx_len != s.len()) || (s.len() > PFX)) return 1'b0;
    for (int i = 0; i < s.len(); i++) begin
      if (lx_pfx[i] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit word_is_arith();
    return word_match("*") || word_match("/") || word_match("-") || word_match("+");
  endfunction

  function automatic bit word_is_relop();
    return word_match(">") || word_match(">=") || word_match("<") ||
           word_match("<=") || word_match("=") || word_match("<>");
  endfunction

  // priority order matters: equals beats relop, keywords beat ident
  function automatic tok_type_t classify_word();
    if (word_match("DIM")) return TT_DIM;
    if (word_match("=")) return TT_EQUALS;
    if (word_match(",")) return TT_COMMA;
    if (word_match(":")) return TT_COLON;
    if (word_match(";")) return TT_SEMI;
    if (word_match("\n")) return TT_NEWLINE;
    if (word_match("AS") || word_match("LET")) return TT_KEYWORD;
    if (word_match("REM")) return TT_REM;
    if (word_is_arith()) return TT_ARITH;
    if (word_is_relop()) return TT_RELOP;
    if (word_match("PRINT") || word_match("GOTO") || word_match("END") ||
        word_match("RND") || word_match("INPUT")) return TT_FUNCTION;
    if ((lx_len > 1) && (lx_pfx[0] == CH_QUOTE) && (lx_prev == CH_QUOTE)) return TT_STRING;
    if (word_match("INTEGER") || word_match("STRING") || word_match("LONG") ||
        word_match("SINGLE") || word_match("DOUBLE")) return TT_TYPE;
    if ((lx_len != 0) && lx_digits) return TT_NUMBER;
    if ((lx_len != 0) && lx_ident) return TT_IDENT;
    return TT_UNDEF;
  endfunction

  function automatic void clear_word();
    lx_len    = 0;
    lx_digits = 1'b1;
    lx_ident  = 1'b1;
  endfunction

  function automatic void lex_reset();
    lx_in_str = 1'b0;
    for (int i = 0; i < PFX; i++) lx_pfx[i] = 8'h00;
    lx_prev = 8'h00;
    clear_word();
  endfunction

  function automatic void emit_token(input tok_type_t t, input int unsigned len);
    if (step_n < 2) begin
      step_tok[step_n].ttype = t;
      step_tok[step_n].tlen  = TOK_LEN_W'((len > TOK_MAX) ? TOK_MAX : len);
      step_tok[step_n].last  = 1'b0;
      step_n++;
    end
  endfunction

  function automatic void flush_word();
    if (lx_len != 0) begin
      emit_token(classify_word(), lx_len);
      clear_word();
    end
  endfunction

  function automatic void append_byte(input logic [7:0] c);
    if (lx_len < PFX) lx_pfx[lx_len] = c;
    lx_digits = lx_digits && is_digit(c);
    if (lx_len == 0) begin
      lx_ident = is_alpha(c);
    end else begin
      lx_ident = lx_ident && (is_alpha(c) || is_digit(c));
    end
    // length saturates, the word keeps growing in classification terms
    if (lx_len < LEN_MAX) lx_len++;
    lx_prev = c;
  endfunction

  // advance the model by one byte; leaves the caused tokens in step_tok
  function automatic void lex_byte(input logic [7:0] c, input bit eos);
    step_n = 0;
    if (!lx_in_str && (c == CH_NL)) begin
      flush_word();
      emit_token(TT_NEWLINE, 1);
    end else if (!lx_in_str && (c != CH_SPACE) && (lx_len != 0)) begin
      // digit run or identifier ends at a foreign byte, operators end themselves
      if ((lx_digits && !is_digit(c)) ||
          (lx_ident && !is_alpha(c) && !is_digit(c)) ||
          word_is_relop() || word_is_arith()) begin
        flush_word();
      end
      append_byte(c);
    end else if (lx_in_str || (c != CH_SPACE)) begin
      // a quote at a word start toggles string mode, the closing one ends the word
      append_byte(c);
      if (c == CH_QUOTE) begin
        if (lx_in_str) flush_word();
        lx_in_str = !lx_in_str;
      end
    end else begin
      flush_word();
    end
    if (eos) begin
      flush_word();
      lex_reset();
    end
    if (step_n > 0) step_tok[step_n-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // queue appends
  function automatic void put_byte(input logic [7:0] c);
    phrase_bytes.insert(phrase_bytes.size(), c);
  endfunction

  function automatic void owe_token(input token_rec_t t);
    pending_tokens.insert(pending_tokens.size(), t);
  endfunction

  function automatic void add_row(input string text, input logic [7:0] raw,
                                  input int unsigned reps, input bit eos, input bit typed,
                                  input tok_type_t ttype, input int unsigned tlen);
    stim_row_t r;
    r.text  = text;
    r.raw   = raw;
    r.reps  = reps;
    r.eos   = eos;
    r.typed = typed;
    r.ttype = ttype;
    r.tlen  = tlen;
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = ($urandom_range(0, 1) != 0) ? "A" : "a";
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  // one random BASIC-like phrase into phrase_bytes, mostly well formed
  task automatic build_phrase();
    int unsigned kind;
    int unsigned n;
    int unsigned r;
    logic [7:0]  c;
    string       w;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      // keyword, type name or function name
      w = kw_words[$urandom_range(0, 13)];
      for (int i = 0; i < w.len(); i++) put_byte(w[i]);
    end else if (kind < 30) begin
      // identifier, now and then longer than the prefix store
      put_byte(rand_letter());
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        put_byte(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter());
      end
    end else if (kind < 42) begin
      // number
      n = ($urandom_range(0, 9) == 0) ? 12 : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) put_byte(rand_digit());
    end else if (kind < 52) begin
      // string literal with arbitrary content, sometimes left open
      put_byte(CH_QUOTE);
      n = $urandom_range(0, 10);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          c = CH_SPACE;
        end else if (r == 1) begin
          c = CH_NL;
        end else begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_QUOTE) c = "q";
        end
        put_byte(c);
      end
      if ($urandom_range(0, 9) != 0) put_byte(CH_QUOTE);
    end else if (kind < 68) begin
      // lone operator or separator byte
      put_byte(op_chars[$urandom_range(0, op_chars.len() - 1)]);
    end else if (kind < 78) begin
      if ($urandom_range(0, 1) != 0) begin
        put_byte(CH_NL);
      end else begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) put_byte(CH_SPACE);
      end
    end else if (kind < 86) begin
      // raw noise over the whole byte range
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
    end else if (kind < 92) begin
      // broken keyword: truncated, possibly with a tail
      w = kw_words[$urandom_range(0, 13)];
      n = $urandom_range(1, w.len() - 1);
      for (int i = 0; i < n; i++) put_byte(w[i]);
      if ($urandom_range(0, 1) != 0) begin
        put_byte(($urandom_range(0, 1) != 0) ? rand_digit() : rand_letter());
      end
    end else begin
      // mixed alphanumeric, may start with a digit
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        put_byte(($urandom_range(0, 1) != 0) ? rand_digit() : rand_letter());
      end
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      put_byte(CH_SPACE);
    end else if (r < 65) begin
      put_byte(CH_NL);
    end
  endtask

  // one input transfer; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] c, input bit eos, input bit typed,
                           input tok_type_t ttype, input int unsigned tlen);
    token_rec_t r;
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 35) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid         <= 1'b1;
    in_source_byte   <= c;
    in_end_of_source <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transfer taken at this edge
    lex_byte(c, eos);
    if (typed) begin
      r.ttype = ttype;
      r.tlen  = TOK_LEN_W'(tlen);
      r.last  = 1'b1;
      owe_token(r);
    end else begin
      for (int i = 0; i < step_n; i++) owe_token(step_tok[i]);
    end
    @(negedge clk);
  endtask

  // hold the sender off until every owed token has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_tokens.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // random backpressure, dropped during the no-idle stretch
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 35);
  end

  always @(posedge clk) begin : check_tokens
    token_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("unexpected token: type %0d len %0d last %0d",
                   out_token_type, out_token_length, out_last_of_step);
        end
        mismatches++;
      end else begin
        want = pending_tokens.pop_front();
        if ((out_token_type !== want.ttype) || (out_token_length !== want.tlen) ||
            (out_last_of_step !== want.last)) begin
          if (mismatches < MAX_REPORTS) begin
            $display("mismatch: exp type %0d len %0d last %0d, got %0d len %0d last %0d",
                     want.ttype, want.tlen, want.last,
                     out_token_type, out_token_length, out_last_of_step);
          end
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_basic_source_lexer failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    stim_row_t   row;
    int unsigned n;
    int unsigned rnd_count;
    int unsigned next_pause;
    logic [7:0]  c;
    bit          eos;
    bit          at_end;

    clk              = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_source_byte   = 8'h00;
    in_end_of_source = 1'b0;
    out_ready        = 1'b0;
    no_idle          = 1'b0;
    mismatches       = 0;
    lex_reset();

    // directed rows; typed rows carry the single token of their last byte
    add_row("\n", 8'h00, 1, 1'b0, 1'b1, TT_NEWLINE, 1);        // newline with no word open
    add_row("=", 8'h00, 1, 1'b1, 1'b1, TT_EQUALS, 1);          // lone equals, flushed at end
    add_row("DIM ", 8'h00, 1, 1'b0, 1'b1, TT_DIM, 3);
    add_row("<>", 8'h00, 1, 1'b1, 1'b0, TT_UNDEF, 0);          // split relop, two tokens on one byte
    add_row("A\"B ", 8'h00, 1, 1'b0, 1'b0, TT_UNDEF, 0);       // quote inside a word
    add_row("\"HI \"", 8'h00, 1, 1'b0, 1'b1, TT_STRING, 5);
    add_row("X\"", 8'h00, 1, 1'b1, 1'b0, TT_UNDEF, 0);         // quote right after a word
    add_row("\"AB", 8'h00, 1, 1'b1, 1'b1, TT_UNDEF, 3);        // string still open at end
    add_row("12+x ", 8'h00, 1, 1'b0, 1'b0, TT_UNDEF, 0);
    add_row("", 8'h00, 1, 1'b0, 1'b0, TT_UNDEF, 0);            // byte extremes
    add_row("", 8'hFF, 1, 1'b0, 1'b0, TT_UNDEF, 0);
    add_row(" ", 8'h00, 1, 1'b0, 1'b0, TT_UNDEF, 0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[k]) begin
      row = stim_rows[k];
      n = (row.text.len() == 0) ? row.reps : row.text.len();
      for (int j = 0; j < n; j++) begin
        c      = (row.text.len() == 0) ? row.raw : row.text[j];
        at_end = (j == n - 1);
        send_byte(c, row.eos && at_end, row.typed && at_end, row.ttype, row.tlen);
      end
    end
    wait_drained();

    // random phrases; spaces between words count for nothing
    rnd_count  = 0;
    next_pause = PAUSE_EVERY;
    while (rnd_count < RANDOM_ITEMS) begin
      build_phrase();
      while (phrase_bytes.size() != 0) begin
        c = phrase_bytes.pop_front();
        if (!((c == CH_SPACE) && !lx_in_str && (lx_len == 0))) rnd_count++;
        no_idle <= (rnd_count >= 300) && (rnd_count < 450);
        if (rnd_count >= next_pause) begin
          next_pause += PAUSE_EVERY;
          wait_drained();
        end
        eos = ($urandom_range(0, 79) == 0);
        send_byte(c, eos, 1'b0, TT_UNDEF, 0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if ((mismatches == 0) && (pending_tokens.size() == 0)) begin
      $display("tb_basic_source_lexer passed");
    end else begin
      $display("tb_basic_source_lexer failed");
    end
    $finish;
  end

endmodule
